FILE: hdl/csres_pkg.sv
// ---------------------------------------------------------------------------
// csres_pkg
// Shared types and constants for the CSR edge search and partition block.
// ---------------------------------------------------------------------------
package csres_pkg;

    localparam int DEF_MAX_NODES = 65536;
    localparam int DEF_MAX_EDGES = 262144;
    localparam int DEF_MAX_PARTS = 1024;

    localparam int OFF_W    = 19;
    localparam int DST_W    = 16;
    localparam int WEIGHT_W = 8;

    typedef enum logic [1:0] {
        OP_LOAD_OFFSET = 2'd0,
        OP_LOAD_EDGE   = 2'd1,
        OP_FIND_EDGE   = 2'd2,
        OP_PARTITION   = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        REG_NODE_COUNT  = 2'd0,
        REG_EDGE_COUNT  = 2'd1,
        REG_NODE_WEIGHT = 2'd2,
        REG_EDGE_WEIGHT = 2'd3
    } t_reg_index;

endpackage

FILE: hdl/csres_ram.sv
// ---------------------------------------------------------------------------
// csres_ram
// Single-port RAM, one access per cycle, registered read data (old data on a write).
// ---------------------------------------------------------------------------
module csres_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/csr_edge_search_and_partition_top.sv
// ---------------------------------------------------------------------------
// csr_edge_search_and_partition_top
// Loads are accepted while idle and give no result. A rejected query raises
// its result strobe in the cycle after it is accepted. Edge lookup reads the
// offsets, then scans neighbors to a hit or the list end. Partition divides
// the weighted size by the part count, then binary-searches the range start
// and, but for the last part, its end. Next start is taken with the strobe.
// Sync active-low reset clears control, counts and results; tables are not.
// ---------------------------------------------------------------------------
module csr_edge_search_and_partition_top #(
    parameter int MAX_NODES = csres_pkg::DEF_MAX_NODES,
    parameter int MAX_EDGES = csres_pkg::DEF_MAX_EDGES,
    parameter int MAX_PARTS = csres_pkg::DEF_MAX_PARTS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_opcode,
    input  logic [17:0] i_entry_index,
    input  logic [18:0] i_entry_value,
    input  logic [15:0] i_src_node,
    input  logic [15:0] i_dst_node,
    input  logic [9:0]  i_part_id,
    input  logic [10:0] i_part_total,
    output logic        o_valid,
    output logic        o_found,
    output logic [17:0] o_edge_index,
    output logic [16:0] o_range_begin,
    output logic [16:0] o_range_end,
    output logic        o_bad_request,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [18:0] i_cfg_data
);

    localparam int NAW  = $clog2(MAX_NODES);
    localparam int EAW  = $clog2(MAX_EDGES);
    localparam int NCW  = $clog2(MAX_NODES + 1);
    localparam int ECW  = $clog2(MAX_EDGES + 1);
    localparam int IW   = (ECW > csres_pkg::OFF_W) ? ECW + 1 : csres_pkg::OFF_W + 1;
    localparam int SZW  = ((NCW > ECW) ? NCW : ECW) + csres_pkg::WEIGHT_W + 1;
    localparam int DVW  = SZW + 1;
    localparam int TW   = DVW + 11;
    localparam int CBW  = ((NCW > csres_pkg::OFF_W) ? NCW : csres_pkg::OFF_W)
                          + csres_pkg::WEIGHT_W + 1;
    localparam int CMW  = (TW > CBW) ? TW : CBW;
    localparam int DCW  = $clog2(DVW + 1);

    typedef enum logic [11:0] {
        S_IDLE = 12'b000000000001,
        S_FRD0 = 12'b000000000010,
        S_FRD1 = 12'b000000000100,
        S_FSET = 12'b000000001000,
        S_SRD  = 12'b000000010000,
        S_SCMP = 12'b000000100000,
        S_SIZE = 12'b000001000000,
        S_DIV  = 12'b000010000000,
        S_TGT  = 12'b000100000000,
        S_LRD  = 12'b001000000000,
        S_LMUL = 12'b010000000000,
        S_LCMP = 12'b100000000000
    } t_state;

    t_state r_state, n_state;

    logic [16:0] r_node_count;
    logic [18:0] r_edge_count;
    logic [7:0]  r_node_weight;
    logic [7:0]  r_edge_weight;

    logic [15:0] r_src, r_dst;
    logic [9:0]  r_pid;
    logic [10:0] r_ptot;

    logic [IW-1:0]  r_b, r_e, r_i;
    logic [DVW-1:0] r_dq;
    logic [11:0]    r_rem;
    logic [DCW-1:0] r_dcnt;
    logic [TW-1:0]  r_tgt;
    logic [NCW-1:0] r_n, r_lo, r_hi, r_mid, r_rb;
    logic           r_phase;
    logic [CBW-1:0] r_p1, r_p2;

    logic        r_valid, r_found, r_bad;
    logic [17:0] r_eidx;
    logic [16:0] r_rbo, r_reo;

    logic accept;
    logic [NCW-1:0] nodes_eff;
    logic [ECW-1:0] edges_eff;

    logic           off_we, edge_we;
    logic [NAW-1:0] off_addr;
    logic [EAW-1:0] edge_addr;
    logic [csres_pkg::OFF_W-1:0] off_rdata;
    logic [csres_pkg::DST_W-1:0] edge_rdata;

    logic [11:0]    div_t;
    logic [NCW-1:0] mid_c;

    assign accept      = i_start && (r_state == S_IDLE);
    assign o_busy      = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    assign nodes_eff = (32'(r_node_count) > 32'(MAX_NODES)) ? NCW'(MAX_NODES)
                                                            : NCW'(r_node_count);
    assign edges_eff = (32'(r_edge_count) > 32'(MAX_EDGES)) ? ECW'(MAX_EDGES)
                                                            : ECW'(r_edge_count);

    assign div_t = {r_rem[10:0], r_dq[DVW-1]};
    assign mid_c = r_lo + ((r_hi - r_lo) >> 1);

    // Table port muxing
    always_comb begin
        off_we    = accept && (i_opcode == csres_pkg::OP_LOAD_OFFSET)
                    && (32'(i_entry_index) < 32'(MAX_NODES));
        edge_we   = accept && (i_opcode == csres_pkg::OP_LOAD_EDGE)
                    && (32'(i_entry_index) < 32'(MAX_EDGES));
        off_addr  = NAW'(i_entry_index);
        edge_addr = EAW'(i_entry_index);
        case (r_state)
            S_FRD0:  off_addr = (r_src == 16'd0) ? '0 : NAW'(r_src - 16'd1);
            S_FRD1:  off_addr = NAW'(r_src);
            S_LRD:   off_addr = NAW'(mid_c);
            default: ;
        endcase
        if (r_state == S_SRD) begin
            edge_addr = EAW'(r_i);
        end
    end

    csres_ram #(.WIDTH(csres_pkg::OFF_W), .DEPTH(MAX_NODES)) u_off_ram (
        .i_clk   (i_clk),
        .i_we    (off_we),
        .i_addr  (off_addr),
        .i_wdata (i_entry_value),
        .o_rdata (off_rdata)
    );

    csres_ram #(.WIDTH(csres_pkg::DST_W), .DEPTH(MAX_EDGES)) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (edge_we),
        .i_addr  (edge_addr),
        .i_wdata (i_entry_value[csres_pkg::DST_W-1:0]),
        .o_rdata (edge_rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_opcode == csres_pkg::OP_FIND_EDGE) begin
                        n_state = (32'(i_src_node) < 32'(nodes_eff)) ? S_FRD0 : S_IDLE;
                    end else if (i_opcode == csres_pkg::OP_PARTITION) begin
                        n_state = (i_part_total == 11'd0
                                   || 32'(i_part_total) > 32'(MAX_PARTS)
                                   || {1'b0, i_part_id} >= i_part_total) ? S_IDLE : S_SIZE;
                    end
                end
            end
            S_FRD0: n_state = S_FRD1;
            S_FRD1: n_state = S_FSET;
            S_FSET: n_state = S_SRD;
            S_SRD:  n_state = (r_i < r_e) ? S_SCMP : S_IDLE;
            S_SCMP: n_state = (edge_rdata == r_dst) ? S_IDLE : S_SRD;
            S_SIZE: n_state = S_DIV;
            S_DIV:  n_state = (r_dcnt == DCW'(DVW - 1)) ? S_TGT : S_DIV;
            S_TGT:  n_state = S_LRD;
            S_LRD: begin
                if (r_lo < r_hi) begin
                    n_state = S_LMUL;
                end else if (!r_phase && ({1'b0, r_pid} + 11'd1 != r_ptot)) begin
                    n_state = S_TGT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_LMUL: n_state = S_LCMP;
            S_LCMP: n_state = S_LRD;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_node_count  <= '0;
            r_edge_count  <= '0;
            r_node_weight <= 8'd8;
            r_edge_weight <= 8'd4;
            r_valid       <= 1'b0;
            r_found       <= 1'b0;
            r_bad         <= 1'b0;
            r_eidx        <= '0;
            r_rbo         <= '0;
            r_reo         <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= ((r_state != S_IDLE) && (n_state == S_IDLE))
                       || (accept && (i_opcode == csres_pkg::OP_FIND_EDGE
                                      || i_opcode == csres_pkg::OP_PARTITION)
                           && (n_state == S_IDLE));
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    csres_pkg::REG_NODE_COUNT:  r_node_count  <= i_cfg_data[16:0];
                    csres_pkg::REG_EDGE_COUNT:  r_edge_count  <= i_cfg_data;
                    csres_pkg::REG_NODE_WEIGHT: r_node_weight <= i_cfg_data[7:0];
                    csres_pkg::REG_EDGE_WEIGHT: r_edge_weight <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (accept && (i_opcode == csres_pkg::OP_FIND_EDGE
                                   || i_opcode == csres_pkg::OP_PARTITION)) begin
                        r_found <= 1'b0;
                        r_eidx  <= '0;
                        r_rbo   <= '0;
                        r_reo   <= '0;
                        r_bad   <= (n_state == S_IDLE);
                    end
                end
                S_SCMP: begin
                    if (edge_rdata == r_dst) begin
                        r_found <= 1'b1;
                        r_eidx  <= 18'(r_i);
                    end
                end
                S_LRD: begin
                    if (!(r_lo < r_hi)) begin
                        if (!r_phase) begin
                            r_rbo <= 17'(r_lo);
                            if ({1'b0, r_pid} + 11'd1 == r_ptot) begin
                                r_reo <= 17'(r_n);
                            end
                        end else begin
                            r_reo <= 17'(r_lo);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_src   <= i_src_node;
            r_dst   <= i_dst_node;
            r_pid   <= i_part_id;
            r_ptot  <= i_part_total;
            r_phase <= 1'b0;
            r_n     <= nodes_eff;
        end
        case (r_state)
            S_FRD1: r_b <= (r_src == 16'd0) ? '0 : IW'(off_rdata);
            S_FSET: begin
                r_e <= (32'(off_rdata) > 32'(edges_eff)) ? IW'(edges_eff) : IW'(off_rdata);
                r_i <= r_b;
            end
            S_SCMP: r_i <= r_i + IW'(1);
            S_SIZE: begin
                r_dq   <= DVW'(r_n * r_node_weight) + DVW'(edges_eff * r_edge_weight)
                          + DVW'(r_ptot) - DVW'(1);
                r_rem  <= '0;
                r_dcnt <= '0;
            end
            S_DIV: begin
                r_dcnt <= r_dcnt + DCW'(1);
                if (div_t >= {1'b0, r_ptot}) begin
                    r_rem <= div_t - {1'b0, r_ptot};
                    r_dq  <= {r_dq[DVW-2:0], 1'b1};
                end else begin
                    r_rem <= div_t;
                    r_dq  <= {r_dq[DVW-2:0], 1'b0};
                end
            end
            S_TGT: begin
                r_tgt <= TW'(r_dq * (r_phase ? {1'b0, r_pid} + 11'd1 : {1'b0, r_pid}));
                r_lo  <= r_phase ? r_rb : '0;
                r_hi  <= r_n;
            end
            S_LRD: begin
                r_mid <= mid_c;
                if (!(r_lo < r_hi) && !r_phase) begin
                    r_rb    <= r_lo;
                    r_phase <= 1'b1;
                end
            end
            S_LMUL: begin
                r_p1 <= CBW'(off_rdata * r_edge_weight);
                r_p2 <= CBW'((r_mid + NCW'(1)) * r_node_weight);
            end
            S_LCMP: begin
                if (CMW'(r_p1) + CMW'(r_p2) < CMW'(r_tgt)) begin
                    r_lo <= r_mid + NCW'(1);
                end else begin
                    r_hi <= r_mid;
                end
            end
            default: ;
        endcase
    end

    assign o_valid       = r_valid;
    assign o_found       = r_found;
    assign o_edge_index  = r_eidx;
    assign o_range_begin = r_rbo;
    assign o_range_end   = r_reo;
    assign o_bad_request = r_bad;

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_busy)
        else $error("result strobe while busy");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_found) |-> (!o_bad_request && o_range_begin == 17'd0))
        else $error("found with bad request or range");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && (i_opcode == csres_pkg::OP_LOAD_OFFSET
                                || i_opcode == csres_pkg::OP_LOAD_EDGE)) |=> !o_valid)
        else $error("load produced a result");

endmodule
